FILE: rtl/core/cht_pkg.sv
// Shared types, constants and the helper function of the convex hull trick line store.
package cht_pkg;

  // Store geometry.
  localparam int MAX_LINES = 1024;
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int IDX_W     = $clog2(MAX_LINES);

  // Field widths.
  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 48;
  localparam int X_W     = 32;
  localparam int VAL_W   = 64;

  // Arithmetic widths: operand differences, multiplier ports and the exact products.
  localparam int DB_W   = ICPT_W + 1;
  localparam int DM_W   = SLOPE_W + 1;
  localparam int MUL_W  = DM_W;
  localparam int MP_W   = 2 * MUL_W;
  localparam int LO_W   = 32;
  localparam int PROD_W = DB_W + DM_W;

  // Width of the index sum 2*lo + hi used by the ternary search.
  localparam int SUM_W = IDX_W + 2;

  localparam logic signed [VAL_W-1:0] EMPTY_ANSWER = 64'sd1000000000000000000;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    func_t                      func;
    logic signed [SLOPE_W-1:0]  slope;
    logic signed [ICPT_W-1:0]   intercept;
    logic signed [X_W-1:0]      xval;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] min_value;
    status_t                 status;
  } rsp_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
  } line_t;

  // One write port and two read ports of the line memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    line_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr0;
    logic [IDX_W-1:0] raddr1;
  } ram_req_t;

  // Floor of s / 3 by a reciprocal multiply and one correction step.
  localparam int DIV3_M = (1 << SUM_W) / 3;

  function automatic logic [SUM_W-1:0] div3(input logic [SUM_W-1:0] s);
    logic [2*SUM_W-1:0] prod;
    logic [SUM_W-1:0]   q;
    logic [SUM_W-1:0]   r;
    prod = s * SUM_W'(DIV3_M);
    q    = prod[2*SUM_W-1:SUM_W];
    r    = s - SUM_W'(q * SUM_W'(3));
    if (r >= SUM_W'(3)) begin
      q = q + SUM_W'(1);
    end
    return q;
  endfunction

endpackage

FILE: rtl/core/convex_hull_trick_min.sv
// Top level of the convex hull trick line store: sequencer, line memory and multipliers.
//
// Lines y = slope*x + intercept must be added with slopes in decreasing order; the
// block does not enforce this. They are kept as a lower envelope in a 1024-entry
// line memory; a query returns the least y at x found by a ternary search. A
// transaction is taken when start is high and busy is low, and exactly one result
// follows, shown for a single cycle with done high; the receiver must take it then,
// since the block cannot hold it. An add to a full store and a query on an empty
// store answer in the next cycle. Any other add keeps busy high while it runs
// redundancy tests, dropping each redundant last line, and then writes the new line;
// the tests stop at a line that is kept or when fewer than two older lines remain
// (there may then be none): each test reads two lines over both memory read ports
// and forms two exact 82-bit cross products in two passes through a pair of 33-bit
// multipliers. A query keeps busy high through its ternary search steps (up to 16
// at 1024 lines); each step reads two lines, multiplies, adds and compares. The
// memory needs no clearing after reset: only entries below the line count are read.
module convex_hull_trick_min
  import cht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output rsp_t result
);

  localparam int SW = CNT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_ADDR,
    S_P_DIFF,
    S_P_MUL1,
    S_P_MUL2,
    S_P_ACC,
    S_WRITE,
    S_Q_ADDR,
    S_Q_MUL,
    S_Q_SUM,
    S_Q_CMP
  } state_t;

  state_t state;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        n;
  line_t                   nl;
  logic signed [X_W-1:0]   xq;
  logic signed [SW-1:0]    lo;
  logic signed [SW-1:0]    hi;
  logic [IDX_W-1:0]        m1;
  logic [IDX_W-1:0]        m2;
  logic signed [DB_W-1:0]  al;
  logic signed [DB_W-1:0]  ar;
  logic signed [DM_W-1:0]  bl;
  logic signed [DM_W-1:0]  br;
  logic signed [MP_W-1:0]  acc_l;
  logic signed [MP_W-1:0]  acc_r;
  logic signed [VAL_W-1:0] y1;
  logic signed [VAL_W-1:0] y2;
  logic signed [VAL_W-1:0] value;

  ram_req_t ram_req;
  line_t    rdata0;
  line_t    rdata1;

  logic signed [MUL_W-1:0] mul_a0, mul_b0, mul_a1, mul_b1;
  logic signed [MP_W-1:0]  mul_p0, mul_p1;

  logic [SUM_W-1:0]         sum1, sum2;
  logic [IDX_W-1:0]         m1_c, m2_c;
  logic                     search_live;
  logic signed [PROD_W-1:0] left_sum, right_sum;
  logic                     redundant;

  cht_line_ram u_ram (
    .clk    (clk),
    .req    (ram_req),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  cht_mul u_mul0 (
    .clk (clk),
    .a   (mul_a0),
    .b   (mul_b0),
    .p   (mul_p0)
  );

  cht_mul u_mul1 (
    .clk (clk),
    .a   (mul_a1),
    .b   (mul_b1),
    .p   (mul_p1)
  );

  assign busy = (state != S_IDLE);

  // Ternary search probe points from the current bounds.
  assign search_live = (lo <= hi);
  assign sum1 = SUM_W'(lo[IDX_W-1:0]) + SUM_W'(lo[IDX_W-1:0]) + SUM_W'(hi[IDX_W-1:0]);
  assign sum2 = SUM_W'(lo[IDX_W-1:0]) + SUM_W'(hi[IDX_W-1:0]) + SUM_W'(hi[IDX_W-1:0]);
  assign m1_c = IDX_W'(div3(sum1));
  assign m2_c = IDX_W'(div3(sum2));

  // Exact cross products: low pass held in acc, high pass arriving now, shifted up.
  assign left_sum  = PROD_W'(acc_l) + (PROD_W'(mul_p0) <<< LO_W);
  assign right_sum = PROD_W'(acc_r) + (PROD_W'(mul_p1) <<< LO_W);
  assign redundant = (left_sum <= right_sum);

  // Memory requests. The sequencer issues one access at a time, so a read never
  // overlaps the write of the same entry.
  always_comb begin
    ram_req.we     = (state == S_WRITE);
    ram_req.waddr  = n[IDX_W-1:0];
    ram_req.wdata  = nl;
    ram_req.re     = 1'b0;
    ram_req.raddr0 = IDX_W'(n - CNT_W'(2));
    ram_req.raddr1 = IDX_W'(n - CNT_W'(1));
    if (state == S_P_ADDR) begin
      ram_req.re = (n >= CNT_W'(2));
    end else if (state == S_Q_ADDR) begin
      ram_req.re     = search_live;
      ram_req.raddr0 = m1_c;
      ram_req.raddr1 = m2_c;
    end
  end

  // Multiplier operands: line values for queries, two passes for cross products.
  always_comb begin
    case (state)
      S_Q_MUL: begin
        mul_a0 = MUL_W'($signed(rdata0.slope));
        mul_b0 = MUL_W'(xq);
        mul_a1 = MUL_W'($signed(rdata1.slope));
        mul_b1 = MUL_W'(xq);
      end
      S_P_MUL1: begin
        mul_a0 = $signed({1'b0, al[LO_W-1:0]});
        mul_b0 = bl;
        mul_a1 = $signed({1'b0, ar[LO_W-1:0]});
        mul_b1 = br;
      end
      default: begin
        mul_a0 = MUL_W'($signed(al[DB_W-1:LO_W]));
        mul_b0 = bl;
        mul_a1 = MUL_W'($signed(ar[DB_W-1:LO_W]));
        mul_b1 = br;
      end
    endcase
  end

  // Sequencer, datapath registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            nl.slope     <= cmd.slope;
            nl.intercept <= cmd.intercept;
            xq           <= cmd.xval;
            n            <= count;
            lo           <= '0;
            hi           <= SW'(count) - SW'(1);
            value        <= EMPTY_ANSWER;
            if (cmd.func == FUNC_ADD) begin
              if (count == CNT_W'(MAX_LINES)) begin
                done             <= 1'b1;
                result.min_value <= '0;
                result.status    <= ST_FULL;
              end else begin
                state <= S_P_ADDR;
              end
            end else begin
              if (count == '0) begin
                done             <= 1'b1;
                result.min_value <= EMPTY_ANSWER;
                result.status    <= ST_EMPTY;
              end else begin
                state <= S_Q_ADDR;
              end
            end
          end
        end

        // Redundancy test of the last stored line against its neighbor and the new line.
        S_P_ADDR: begin
          if (n >= CNT_W'(2)) begin
            state <= S_P_DIFF;
          end else begin
            state <= S_WRITE;
          end
        end
        S_P_DIFF: begin
          al    <= DB_W'($signed(nl.intercept)) - DB_W'($signed(rdata0.intercept));
          bl    <= DM_W'($signed(rdata0.slope)) - DM_W'($signed(rdata1.slope));
          ar    <= DB_W'($signed(rdata1.intercept)) - DB_W'($signed(rdata0.intercept));
          br    <= DM_W'($signed(rdata0.slope)) - DM_W'($signed(nl.slope));
          state <= S_P_MUL1;
        end
        S_P_MUL1: begin
          state <= S_P_MUL2;
        end
        S_P_MUL2: begin
          acc_l <= mul_p0;
          acc_r <= mul_p1;
          state <= S_P_ACC;
        end
        S_P_ACC: begin
          if (redundant) begin
            n     <= n - CNT_W'(1);
            state <= S_P_ADDR;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          count            <= n + CNT_W'(1);
          done             <= 1'b1;
          result.min_value <= '0;
          result.status    <= ST_OK;
          state            <= S_IDLE;
        end

        // Ternary search with minimum tracking.
        S_Q_ADDR: begin
          if (search_live) begin
            m1    <= m1_c;
            m2    <= m2_c;
            state <= S_Q_MUL;
          end else begin
            done             <= 1'b1;
            result.min_value <= value;
            result.status    <= ST_OK;
            state            <= S_IDLE;
          end
        end
        S_Q_MUL: begin
          state <= S_Q_SUM;
        end
        S_Q_SUM: begin
          y1    <= VAL_W'(mul_p0) + VAL_W'($signed(rdata0.intercept));
          y2    <= VAL_W'(mul_p1) + VAL_W'($signed(rdata1.intercept));
          state <= S_Q_CMP;
        end
        S_Q_CMP: begin
          if (y1 < y2) begin
            if (y1 < value) begin
              value <= y1;
            end
            hi <= SW'(m2) - SW'(1);
          end else begin
            if (y2 < value) begin
              value <= y2;
            end
            lo <= SW'(m1) + SW'(1);
          end
          state <= S_Q_ADDR;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A full-store report only comes when the store really is full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> (count == CNT_W'(MAX_LINES)))
    else $error("full status reported while the store has room");

  // An empty-store report comes with an empty store and the fixed answer.
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> (count == '0 && result.min_value == EMPTY_ANSWER))
    else $error("empty status reported inconsistently");

  // The line count only moves when an add transaction completes.
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> done)
    else $error("line count changed without a completed add");

endmodule

FILE: rtl/core/cht_line_ram.sv
// Line memory: one write port and two registered read ports.
module cht_line_ram
  import cht_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output line_t    rdata0,
  output line_t    rdata1
);

  line_t mem [MAX_LINES];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read ports; the data holds between reads.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata0 <= mem[req.raddr0];
      rdata1 <= mem[req.raddr1];
    end
  end

endmodule

FILE: rtl/core/cht_mul.sv
// Registered signed multiplier shared by the line evaluation and the redundancy test.
module cht_mul
  import cht_pkg::*;
(
  input  logic                    clk,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  output logic signed [MP_W-1:0]  p
);

  // One product per cycle, result registered.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
